/* src/evhc_pkg.sv */
// Package for the escape value HSV colorizer.
// Holds fixed-point constants and shared types; depends on nothing.
package evhc_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int INT_BITS_DEF  = 16;
    localparam int Q = 30;
    localparam int DIV_STEPS = 4;

    typedef logic [Q:0] q30_t;

    typedef struct packed {
        logic [2:0] sector;
        q30_t       frac;
    } hue_t;

endpackage

/* src/evhc_divider.sv */
// Pipelined restoring divider: quotient = floor(2^62 / den), den >= 2^32.
// Uses evhc_pkg; the quotient is at most 2^30 so 31 quotient bits suffice.
module evhc_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] den,
    input  logic        in_sat,
    output logic        out_valid,
    output logic        out_sat,
    output logic [30:0] quo
);
    import evhc_pkg::*;

    localparam int NBITS = 31;
    localparam int PER = (NBITS + DIV_STEPS - 1) / DIV_STEPS;

    logic [DIV_STEPS:0]       v_reg;
    logic [DIV_STEPS:0]       s_reg;
    logic [63:0]              d_reg [DIV_STEPS+1];
    logic [63:0]              r_reg [DIV_STEPS+1];
    logic [NBITS-1:0]         q_reg [DIV_STEPS+1];

    // Stage 0 holds the remainder 2^62; quotient bits are found from bit 30 down.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[DIV_STEPS-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= den;
            r_reg[0] <= 64'd1 << 62;
            q_reg[0] <= '0;
            s_reg[0] <= in_sat;
        end
    end

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_step
        logic [63:0]      r_next;
        logic [NBITS-1:0] q_next;
        always_comb
        begin
            logic [95:0] dd;
            dd     = '0;
            r_next = r_reg[s];
            q_next = q_reg[s];
            for (int k = 0; k < PER; k++)
            begin
                if (s * PER + k < NBITS)
                begin
                    dd = {32'd0, d_reg[s]} << (NBITS - 1 - (s * PER + k));
                    if ({32'd0, r_next} >= dd)
                    begin
                        r_next = r_next - dd[63:0];
                        q_next[NBITS - 1 - (s * PER + k)] = 1'b1;
                    end
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[s+1] <= d_reg[s];
                r_reg[s+1] <= r_next;
                q_reg[s+1] <= q_next;
                s_reg[s+1] <= s_reg[s];
            end
        end
    end

    assign out_valid = v_reg[DIV_STEPS];
    assign out_sat   = s_reg[DIV_STEPS];
    assign quo       = q_reg[DIV_STEPS];

endmodule

/* src/evhc_hue.sv */
// Hue path: sector and in-sector fraction from the escape value mod 100.
// Uses evhc_pkg; five register stages, delay matched by the top level.
module evhc_hue #(
    parameter int FRAC_BITS = evhc_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS  = evhc_pkg::INT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [INT_BITS+FRAC_BITS-1:0] raw,
    output evhc_pkg::hue_t                hue
);
    import evhc_pkg::*;

    localparam int     XW   = FRAC_BITS + 7;   // holds raw mod SPAN
    localparam int     HW   = XW + 3;          // holds six times that
    localparam int     QW   = FRAC_BITS + 2;   // holds (raw mod SPAN) / 25
    localparam longint SPAN = 64'd100 << FRAC_BITS;
    // The fraction (r << (Q - FRAC_BITS)) / 100 equals (r << S) / 25.
    localparam int     S    = Q - 2 - FRAC_BITS;
    // Reciprocals: n / 100 is exact for n < 2^15, r / 25 for r < 2^23.
    localparam longint M100 = ((64'd1 << 22) + 64'd99) / 64'd100;
    localparam longint M25  = ((64'd1 << 28) + 64'd24) / 64'd25;
    // k * 2^S / 25 for a remainder k below 25, by a short multiply.
    localparam longint MT   = ((64'd1 << (S + 10)) + 64'd24) / 64'd25;

    logic [15:0]          fold_next, fold_reg;
    logic [FRAC_BITS-1:0] lo_reg;
    logic [XW-1:0]        xm_next, xm_reg;
    logic [2:0]           sec_next, sec_c_reg, sec_d_reg, sec_e_reg;
    logic [XW-1:0]        r_next, r_c_reg, r_d_reg;
    logic [QW-1:0]        q25_next, q25_reg;
    logic [Q-1:0]         frac_next, frac_reg;

    // Stage A: fold the integer part bytewise, using 256^k mod 100.
    always_comb
    begin
        logic [31:0] n_int;
        n_int     = 32'(raw >> FRAC_BITS);
        fold_next = 16'(n_int[7:0]) + 16'(n_int[15:8]) * 16'd56
                  + 16'(n_int[23:16]) * 16'd36 + 16'(n_int[31:24]) * 16'd16;
    end

    // Stage B: finish the integer part mod 100 and rejoin the fraction bits.
    always_comb
    begin
        logic [31:0] qp;
        logic [8:0]  q100;
        qp      = 32'(fold_reg) * 32'(M100);
        q100    = 9'(qp >> 22);
        xm_next = {7'(fold_reg - 16'(q100) * 16'd100), lo_reg};
    end

    // Stage C: six times the hue, split into a sector and its remainder.
    always_comb
    begin
        logic [HW-1:0] h6;
        logic [HW-1:0] base;
        h6       = HW'(xm_reg) * HW'(6);
        sec_next = '0;
        base     = '0;
        for (int k = 1; k < 6; k++)
        begin
            if (h6 >= HW'(SPAN * k))
            begin
                sec_next = 3'(k);
                base     = HW'(SPAN * k);
            end
        end
        r_next = XW'(h6 - base);
    end

    // Stage D: remainder divided by 25.
    always_comb
    begin
        logic [47:0] prod;
        prod     = 48'(r_c_reg) * 48'(M25);
        q25_next = QW'(prod >> 28);
    end

    // Stage E: fraction as the quotient shifted up plus the remainder's tail.
    always_comb
    begin
        logic [4:0]  rem25;
        logic [39:0] tail;
        rem25     = 5'(r_d_reg - XW'(q25_reg) * XW'(25));
        tail      = (40'(rem25) * 40'(MT)) >> 10;
        frac_next = (Q'(q25_reg) << S) + Q'(tail);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fold_reg  <= fold_next;
            lo_reg    <= raw[FRAC_BITS-1:0];
            xm_reg    <= xm_next;
            sec_c_reg <= sec_next;
            r_c_reg   <= r_next;
            sec_d_reg <= sec_c_reg;
            r_d_reg   <= r_c_reg;
            q25_reg   <= q25_next;
            sec_e_reg <= sec_d_reg;
            frac_reg  <= frac_next;
        end
    end

    assign hue.sector = sec_e_reg;
    assign hue.frac   = {1'b0, frac_reg};

endmodule

/* src/escape_value_hsv_colorizer.sv */
// Escape value HSV colorizer top level: Lorentz brightness cubed, hue from
// the escape value mod 100, six-sector HSV to RGB, one pixel per clock
// while not stalled. From acceptance to the output word there are two front
// stages, five divider stages, three Lorentz and cube stages, two chroma
// stages and the output register; the hue path runs alongside. Throughput is
// one word per cycle while not stalled. A stall freezes the whole pipeline;
// the output register holds its word. Asynchronous active-low reset clears
// valid bits and sets saturation to 128.
module escape_value_hsv_colorizer #(
    parameter int FRAC_BITS = evhc_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS  = evhc_pkg::INT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // s_axis_tdata: escape_value
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [((INT_BITS+FRAC_BITS+7)/8)*8-1:0] s_axis_tdata,
    // m_axis_tdata: red [7:0], green [15:8], blue [23:16]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [23:0]                   m_axis_tdata,
    input  logic                          cfg_we,
    input  logic [7:0]                    cfg_wdata
);
    import evhc_pkg::*;

    localparam int W = INT_BITS + FRAC_BITS;
    localparam int HL = 5;                 // register stages in the hue module

    // The pipeline advances whenever the output slot is empty or being taken.
    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic [7:0] sat_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= 8'd128;
        end
        else if (cfg_we)
        begin
            sat_reg <= cfg_wdata;
        end
    end

    logic [W-1:0] raw;
    assign raw = s_axis_tdata[W-1:0];

    // Stage 1: saturate test and widen to Q15.16; stage 2: square plus one.
    logic        v1_reg;
    logic        s1_reg;
    logic [31:0] xr_reg;
    logic [63:0] den_reg;
    logic        v2_reg;
    logic        s2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= (W'(raw) >> (FRAC_BITS + 15)) != '0;
            xr_reg  <= 32'(raw) << (16 - FRAC_BITS);
            s2_reg  <= s1_reg;
            den_reg <= 64'(xr_reg) * 64'(xr_reg) + (64'd1 << 32);
        end
    end

    logic        dv;
    logic        dsat;
    logic [30:0] dq;
    evhc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v2_reg),
        .den      (den_reg),
        .in_sat   (s2_reg),
        .out_valid(dv),
        .out_sat  (dsat),
        .quo      (dq)
    );

    // Lorentz value, then square, then cube; each multiply registered.
    q30_t lor_reg, l2_reg, lc_reg, v_reg;
    logic vl_reg, vs_reg, vc_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vl_reg <= 1'b0;
            vs_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            vl_reg <= dv;
            vs_reg <= vl_reg;
            vc_reg <= vs_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lor_reg <= dsat ? q30_t'(1 << Q) : q30_t'((1 << Q) - 31'(dq));
            l2_reg  <= q30_t'((64'(lor_reg) * 64'(lor_reg)) >> Q);
            lc_reg  <= lor_reg;
            v_reg   <= q30_t'((64'(l2_reg) * 64'(lc_reg)) >> Q);
        end
    end

    // Hue path runs in parallel; its raw input is delayed to align with V.
    localparam int VL = 2 + DIV_STEPS + 1 + 3;  // stages up to v_reg
    localparam int HD = VL - HL;
    logic [W-1:0] rd_reg [HD];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_reg[0] <= raw;
        end
    end
    for (genvar i = 0; i < HD - 1; i++)
    begin : g_rd
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rd_reg[i+1] <= rd_reg[i];
            end
        end
    end

    hue_t hue;
    evhc_hue #(.FRAC_BITS(FRAC_BITS), .INT_BITS(INT_BITS)) u_hue (
        .clk(clk),
        .en (en),
        .raw(rd_reg[HD-1]),
        .hue(hue)
    );

    // Chroma stages.
    q30_t c_reg, m_reg, t_reg;
    logic [2:0] sc_reg, sx_reg;
    logic vx_reg, vo_reg;
    q30_t cx_reg, mx_reg, x_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vx_reg        <= 1'b0;
            vo_reg        <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end
        else if (en)
        begin
            vx_reg        <= vc_reg;
            vo_reg        <= vx_reg;
            m_axis_tvalid <= vo_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg  <= q30_t'((40'(v_reg) * 40'(sat_reg)) >> 8);
            m_reg  <= v_reg - q30_t'((40'(v_reg) * 40'(sat_reg)) >> 8);
            t_reg  <= hue.sector[0] ? q30_t'(1 << Q) - hue.frac : hue.frac;
            sc_reg <= hue.sector;
            x_reg  <= q30_t'((64'(c_reg) * 64'(t_reg)) >> Q);
            cx_reg <= c_reg;
            mx_reg <= m_reg;
            sx_reg <= sc_reg;
        end
    end

    // Sector mux and byte conversion into the output register.
    q30_t r, g, b;
    always_comb
    begin
        case (sx_reg)
            3'd0: begin r = cx_reg; g = x_reg;  b = '0;     end
            3'd1: begin r = x_reg;  g = cx_reg; b = '0;     end
            3'd2: begin r = '0;     g = cx_reg; b = x_reg;  end
            3'd3: begin r = '0;     g = x_reg;  b = cx_reg; end
            3'd4: begin r = x_reg;  g = '0;     b = cx_reg; end
            default: begin r = cx_reg; g = '0;  b = x_reg;  end
        endcase
    end

    function automatic logic [7:0] to_byte(input q30_t ch, input q30_t m);
        logic [39:0] p;
        p = 40'(ch + m) * 40'd255;
        return p[Q+7:Q];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_axis_tdata <= {to_byte(b, mx_reg), to_byte(g, mx_reg), to_byte(r, mx_reg)};
        end
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output word changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("pipeline not ready with empty output");
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped under stall");
`endif

endmodule

/* sim/tb_escape_value_hsv_colorizer.sv */
// Self-checking testbench for the escape value HSV colorizer.
// Drives escape values over the input stream and checks every RGB word
// against a fixed-point colorizer predictor; depends on evhc_pkg and the RTL.
module tb_escape_value_hsv_colorizer;

    localparam int FRAC_BITS = evhc_pkg::FRAC_BITS_DEF;
    localparam int INT_BITS  = evhc_pkg::INT_BITS_DEF;
    localparam int IN_W      = INT_BITS + FRAC_BITS;
    localparam int TD_W      = ((IN_W + 7) / 8) * 8;
    localparam int DRAIN     = 40;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [TD_W-1:0] s_axis_tdata = '0;
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [23:0]     m_axis_tdata;
    logic            cfg_we = 1'b0;
    logic [7:0]      cfg_wdata = '0;

    escape_value_hsv_colorizer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #4 clk = ~clk;

    // Escape values waiting to be driven, and the RGB words they should produce.
    logic [IN_W-1:0] pending_escapes[$];
    logic [23:0]     expected_pixels[$];
    // Saturation as the testbench believes the block holds it.
    logic [7:0]      model_saturation = 8'd128;
    int              mismatches = 0;
    int              pixels_seen = 0;
    bit              stall_hold = 1'b0;   // long receiver hold-off
    bit              quiet_phase = 1'b0;  // no random idling in this phase
    int              stall_cycles = 0;

    // Predicts one RGB word. Brightness is the cube of the Lorentz curve in
    // Q1.30, hue is the value mod 100 split into six sectors.
    function automatic logic [23:0] colorize(input logic [IN_W-1:0] esc,
                                             input logic [7:0] sat);
        logic [63:0] one30, lor, l2, v, xr, den, span, xm, h6, sector;
        logic [63:0] frac, c, m, t, xv, r, g, b;
        logic [7:0]  rb, gb, bb;
        one30 = 64'd1 << 30;
        if (esc >= (64'd1 << (FRAC_BITS + 15)))
            lor = one30;
        else
        begin
            xr  = 64'(esc) << (16 - FRAC_BITS);
            den = xr * xr + (64'd1 << 32);
            lor = one30 - ((64'd1 << 62) / den);
        end
        l2 = (lor * lor) >> 30;
        v  = (l2 * lor) >> 30;
        span   = 64'd100 << FRAC_BITS;
        xm     = 64'(esc) % span;
        h6     = 6 * xm;
        sector = h6 / span;
        frac   = ((h6 % span) << 30) / span;
        c  = (v * 64'(sat)) >> 8;
        m  = v - c;
        t  = sector[0] ? one30 - frac : frac;
        xv = (c * t) >> 30;
        case (sector)
            0: begin r = c;  g = xv; b = 0;  end
            1: begin r = xv; g = c;  b = 0;  end
            2: begin r = 0;  g = c;  b = xv; end
            3: begin r = 0;  g = xv; b = c;  end
            4: begin r = xv; g = 0;  b = c;  end
            default: begin r = c; g = 0; b = xv; end
        endcase
        rb = 8'((255 * (r + m)) >> 30);
        gb = 8'((255 * (g + m)) >> 30);
        bb = 8'((255 * (b + m)) >> 30);
        return {bb, gb, rb};
    endfunction

    // Appends one escape value to the pending queue.
    task automatic queue_escape(input logic [IN_W-1:0] esc);
        pending_escapes = {pending_escapes, esc};
    endtask

    // Driver: offers the next pending escape value, idling now and then.
    // The prediction is made at acceptance with the saturation then in force.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_pixels = {expected_pixels,
                                   colorize(s_axis_tdata[IN_W-1:0], model_saturation)};
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_escapes.size() > 0
                    && (quiet_phase || $urandom_range(99) >= 30))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= TD_W'(pending_escapes.pop_front());
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted RGB word against the oldest prediction.
    always @(posedge clk)
    begin
        logic [23:0] want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                pixels_seen++;
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected word %h", m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (m_axis_tdata[7:0] !== want[7:0])
                    begin
                        $error("red: expected %0d, actual %0d", want[7:0],
                               m_axis_tdata[7:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[15:8] !== want[15:8])
                    begin
                        $error("green: expected %0d, actual %0d", want[15:8],
                               m_axis_tdata[15:8]);
                        mismatches++;
                    end
                    if (m_axis_tdata[23:16] !== want[23:16])
                    begin
                        $error("blue: expected %0d, actual %0d", want[23:16],
                               m_axis_tdata[23:16]);
                        mismatches++;
                    end
                end
            end
            // The long hold-off is counted here so the pipeline backs up.
            if (stall_hold)
            begin
                stall_cycles++;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= quiet_phase || ($urandom_range(99) >= 30);
        end
    end

    // Waits until every queued value is accepted and every word is back,
    // then lets the pipeline run dry before the saturation may change.
    task automatic drain_pipeline();
        while (pending_escapes.size() > 0 || s_axis_tvalid
               || expected_pixels.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic set_saturation(input logic [7:0] sat);
        cfg_we    <= 1'b1;
        cfg_wdata <= sat;
        @(posedge clk);
        cfg_we    <= 1'b0;
        model_saturation = sat;
    endtask

    // Random escape value: half of them small, where brightness and hue vary fast,
    // some anywhere in the field, some at or above the saturation point.
    function automatic logic [IN_W-1:0] random_escape();
        case ($urandom_range(3))
            0: return IN_W'($urandom_range(12 << FRAC_BITS));
            1: return IN_W'($urandom_range(100 << FRAC_BITS));
            2: return IN_W'($urandom);
            default: return IN_W'($urandom_range((1 << IN_W) - 1,
                                                 1 << (FRAC_BITS + 15)));
        endcase
    endfunction

    logic [7:0] sat_plan[6] = '{8'd128, 8'd0, 8'd255, 8'd1, 8'd200, 8'd77};

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero, the smallest step, the brightness saturation point
        // and its neighbor, the field's maximum, every hue sector boundary,
        // and a value just under 100 where hue wraps. Reset saturation.
        queue_escape('0);
        queue_escape(IN_W'(1));
        queue_escape(IN_W'(1 << FRAC_BITS));
        queue_escape(IN_W'((1 << (FRAC_BITS + 15)) - 1));
        queue_escape(IN_W'(1 << (FRAC_BITS + 15)));
        queue_escape({IN_W{1'b1}});
        queue_escape(IN_W'(24'haaaaaa));
        queue_escape(IN_W'(24'h555555));
        for (int s = 0; s < 6; s++)
            queue_escape(IN_W'(((100 << FRAC_BITS) * s) / 6 + 1));
        queue_escape(IN_W'((100 << FRAC_BITS) - 1));
        queue_escape(IN_W'(100 << FRAC_BITS));
        queue_escape(IN_W'((1 << FRAC_BITS) + 37));
        drain_pipeline();

        // Random phases over several saturations; one runs with no idling.
        for (int ph = 0; ph < 6; ph++)
        begin
            set_saturation(sat_plan[ph]);
            quiet_phase = (ph == 3);
            for (int i = 0; i < 90; i++)
                queue_escape(random_escape());
            if (ph == 2)
            begin
                // Hold the receiver off while the sender keeps offering.
                while (pending_escapes.size() > 60) @(posedge clk);
                stall_hold = 1'b1;
                while (stall_cycles < 60) @(posedge clk);
                stall_hold = 1'b0;
            end
            drain_pipeline();
        end
        quiet_phase = 1'b0;

        $display("Checked %0d pixels over saturations 128, 0, 255, 1, 200, 77,",
                 pixels_seen);
        $display("including field extremes, hue sectors and a long output stall.");
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
